>>> rtl/srfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the sensor response frame checker.
// No dependencies; imported by every module of the block.
package srfc_pkg;

	// crc-8 of each response word
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// frame kinds, shared by the op input and the kind output
	localparam logic [1:0] KIND_MEAS   = 2'd0;
	localparam logic [1:0] KIND_SERIAL = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// byte positions inside a frame; the second crc byte takes the default arm
	localparam logic [2:0] POS_HI0  = 3'd0;
	localparam logic [2:0] POS_LO0  = 3'd1;
	localparam logic [2:0] POS_CRC0 = 3'd2;
	localparam logic [2:0] POS_HI1  = 3'd3;
	localparam logic [2:0] POS_LO1  = 3'd4;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_TEMP_MIN = 2'd0;
	localparam logic [1:0] REG_TEMP_MAX = 2'd1;
	localparam logic [1:0] REG_HUM_MIN  = 2'd2;
	localparam logic [1:0] REG_HUM_MAX  = 2'd3;

	// configuration reset values
	localparam logic [14:0] TEMP_MIN_RST = 15'h7060;  // -4000
	localparam logic [14:0] TEMP_MAX_RST = 15'd12500;
	localparam logic [13:0] HUM_MIN_RST  = 14'd0;
	localparam logic [13:0] HUM_MAX_RST  = 14'd10000;

	// conversion constants
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'hEE6C;   // -4500

	// status word flag bits
	localparam int HEATER_BIT = 13;
	localparam int ALERT_BIT  = 15;
	localparam int RESET_BIT  = 4;

	// range limits from the configuration registers
	typedef struct packed {
		logic [14:0] temp_min;
		logic [14:0] temp_max;
		logic [13:0] hum_min;
		logic [13:0] hum_max;
	} limits_t;

	// completed frame handed from the frame tracker to the converter
	typedef struct packed {
		logic [1:0]  kind;
		logic        crc_ok;
		logic [15:0] word0;
		logic [15:0] word1;
	} frame_word_t;

	// decoded result item
	typedef struct packed {
		logic [1:0]  kind;
		logic        crc_ok;
		logic        in_range;
		logic [14:0] temperature_centi;
		logic [13:0] humidity_centi;
		logic [31:0] word_value;
		logic        heater_on;
		logic        alert_pending;
		logic        reset_detected;
	} result_t;

	// crc-8 over one byte, msb first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] c;
		c = acc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// floor(x / 65535) for x below 2^31, by adding the high half back in
	function automatic logic [15:0] div_65535(input logic [31:0] x);
		logic [31:0] s;
		s = x + {16'd0, x[31:16]} + 32'd1;
		return s[31:16];
	endfunction

endpackage

>>> rtl/srfc_frame.sv
`timescale 1ns / 1ps
// Frame tracker: byte position, frame kind, running crc-8 and the received words.
// Depends on srfc_pkg.
module srfc_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_op,
	input  logic                 in_start,
	input  logic [7:0]           in_byte,
	output logic                 in_go,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srfc_pkg::frame_word_t out_word
);
	import srfc_pkg::*;

	logic        active_q, active_d;
	logic [2:0]  pos_q, pos_d, pos_cur;
	logic [1:0]  kind_q, kind_d;
	logic [7:0]  crc_q, crc_d;
	logic [15:0] word0_q, word0_d;
	logic [15:0] word1_q, word1_d;
	logic        good0_q, good0_d;
	logic        emit;
	logic        frame_ok;
	logic        update;

	// next frame state for the byte held at the input register
	always_comb begin
		active_d = active_q;
		pos_d    = pos_q;
		kind_d   = kind_q;
		crc_d    = crc_q;
		word0_d  = word0_q;
		word1_d  = word1_q;
		good0_d  = good0_q;
		emit     = 1'b0;
		frame_ok = 1'b0;
		pos_cur  = pos_q;

		// a start byte restarts the frame, an unused kind just closes it
		if (in_start) begin
			pos_d = 3'd0;
			if (in_op == KIND_NONE) begin
				active_d = 1'b0;
			end else begin
				active_d = 1'b1;
				kind_d   = in_op;
				crc_d    = CRC_INIT;
				word0_d  = 16'd0;
				word1_d  = 16'd0;
				good0_d  = 1'b0;
			end
		end

		if (active_d) begin
			pos_cur = pos_d;
			pos_d   = pos_cur + 3'd1;
			case (pos_cur)
				POS_HI0: begin
					crc_d   = crc8_byte(crc_d, in_byte);
					word0_d = {in_byte, 8'h00};
				end
				POS_LO0: begin
					crc_d   = crc8_byte(crc_d, in_byte);
					word0_d = {word0_d[15:8], in_byte};
				end
				POS_CRC0: begin
					good0_d = (in_byte == crc_d);
					crc_d   = CRC_INIT;
					if (kind_d == KIND_STATUS) begin
						active_d = 1'b0;
						pos_d    = 3'd0;
						emit     = 1'b1;
						frame_ok = good0_d;
					end
				end
				POS_HI1: begin
					crc_d   = crc8_byte(crc_d, in_byte);
					word1_d = {in_byte, 8'h00};
				end
				POS_LO1: begin
					crc_d   = crc8_byte(crc_d, in_byte);
					word1_d = {word1_d[15:8], in_byte};
				end
				default: begin
					frame_ok = good0_d && (in_byte == crc_d);
					crc_d    = CRC_INIT;
					active_d = 1'b0;
					pos_d    = 3'd0;
					emit     = 1'b1;
				end
			endcase
		end
	end

	// the byte moves on unless its result cannot be handed over
	assign in_go     = !emit || out_ready;
	assign update    = in_valid && in_go;
	assign out_valid = in_valid && emit;

	assign out_word.kind   = kind_d;
	assign out_word.crc_ok = frame_ok;
	assign out_word.word0  = word0_d;
	assign out_word.word1  = word1_d;

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= 3'd0;
			kind_q   <= KIND_MEAS;
			crc_q    <= CRC_INIT;
			word0_q  <= 16'd0;
			word1_q  <= 16'd0;
			good0_q  <= 1'b0;
		end else if (update) begin
			active_q <= active_d;
			pos_q    <= pos_d;
			kind_q   <= kind_d;
			crc_q    <= crc_d;
			word0_q  <= word0_d;
			word1_q  <= word1_d;
			good0_q  <= good0_d;
		end
	end

endmodule

>>> rtl/srfc_convert.sv
`timescale 1ns / 1ps
// Result pipeline: frame capture, constant scaling, divide by 65535, range check, output register.
// Depends on srfc_pkg.
module srfc_convert (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  srfc_pkg::frame_word_t in_word,
	input  srfc_pkg::limits_t     limits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output srfc_pkg::result_t     out_result
);
	import srfc_pkg::*;

	logic        valid_s2;
	frame_word_t word_s2;
	logic        valid_s3;
	frame_word_t word_s3;
	logic [30:0] temp_prod_s3;
	logic [29:0] hum_prod_s3;
	logic        valid_q;
	result_t     result_q;

	logic        adv_out, adv_s3, adv_s2;
	logic [15:0] temp_quot, hum_quot;
	logic [15:0] temp_full;
	logic [14:0] temp_c;
	logic [13:0] hum_c;
	logic        limits_ok;
	result_t     result_c;

	// each stage moves when the next one is empty or moving
	assign adv_out  = !valid_q || out_ready;
	assign adv_s3   = !valid_s3 || adv_out;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign in_ready = adv_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= in_valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_out) begin
				valid_q <= valid_s3;
			end
		end
	end

	// payload: capture, then scale by the constant factors
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			word_s2 <= in_word;
		end
		if (adv_s3) begin
			word_s3      <= word_s2;
			temp_prod_s3 <= 31'(word_s2.word0) * 31'(TEMP_SCALE);
			hum_prod_s3  <= 30'(word_s2.word1) * 30'(HUM_SCALE);
		end
		if (adv_out) begin
			result_q <= result_c;
		end
	end

	// divide by full scale, offset and compare against the limits
	always_comb begin
		temp_quot = div_65535({1'b0, temp_prod_s3});
		hum_quot  = div_65535({2'b00, hum_prod_s3});
		temp_full = {1'b0, temp_quot[14:0]} + TEMP_OFFSET;
		temp_c    = temp_full[14:0];
		hum_c     = hum_quot[13:0];
		limits_ok = ($signed(temp_c) >= $signed(limits.temp_min)) &&
			($signed(temp_c) <= $signed(limits.temp_max)) &&
			(hum_c >= limits.hum_min) && (hum_c <= limits.hum_max);

		result_c                   = '0;
		result_c.kind              = word_s3.kind;
		result_c.crc_ok            = word_s3.crc_ok;
		case (word_s3.kind)
			KIND_MEAS: begin
				result_c.in_range          = word_s3.crc_ok && limits_ok;
				result_c.temperature_centi = temp_c;
				result_c.humidity_centi    = hum_c;
			end
			KIND_SERIAL: begin
				result_c.word_value = {word_s3.word0, word_s3.word1};
			end
			default: begin
				result_c.word_value     = {16'd0, word_s3.word0};
				result_c.heater_on      = word_s3.word0[HEATER_BIT];
				result_c.alert_pending  = word_s3.word0[ALERT_BIT];
				result_c.reset_detected = word_s3.word0[RESET_BIT];
			end
		endcase
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

>>> rtl/sensor_response_frame_checker.sv
`timescale 1ns / 1ps
// Top level of the sensor response frame checker: stream ports, input register, config registers.
// Depends on srfc_pkg, srfc_frame and srfc_convert.
//
// Usage:
//   The slave stream takes one response byte per transfer. The first byte of a frame
//   carries frame_start and the frame kind in s_tuser. Measurement and serial frames
//   are six bytes (two words, each followed by its crc-8 byte), status frames three.
//   On the last byte of a frame one result transfer leaves on the master stream with
//   the crc verdict and the decoded values; all other bytes produce no transfer.
//   Throughput: one byte per cycle while the result path is not stalled. The frame state
//   (crc, position, words) updates once per byte behind the input register.
//   After the last byte enters the input register, the result moves through frame capture
//   and constant multiply, then divide/compare into the output register.
//   A stalled master side holds the result in the output register; the stages behind
//   it keep filling, and bytes are still taken until a further result has nowhere to go.
//   Reset clears all frame state and loads the default limits; no frame is open after
//   reset. The APB port writes the four limit registers, at byte addresses 0, 4, 8, 12,
//   and should only be written while no frame is in flight.
module sensor_response_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [2:0]  s_tuser,   // [1:0] op, [2] frame_start
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] crc_ok, [1] in_range, [16:2] temperature_centi, [30:17] humidity_centi,
	// [62:31] word_value, [63] heater_on, [64] alert_pending, [65] reset_detected,
	// [71:66] zero
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] kind
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srfc_pkg::*;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic        start_s1;
	logic [7:0]  byte_s1;
	limits_t     limits_q;
	logic        frame_go;
	logic        frame_valid;
	logic        conv_ready;
	frame_word_t frame_word;
	result_t     result;
	logic        cfg_write;

	// input register
	assign s_tready = !valid_s1 || frame_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser[1:0];
			start_s1 <= s_tuser[2];
			byte_s1  <= s_tdata;
		end
	end

	// frame tracking and crc
	srfc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_op     (op_s1),
		.in_start  (start_s1),
		.in_byte   (byte_s1),
		.in_go     (frame_go),
		.out_valid (frame_valid),
		.out_ready (conv_ready),
		.out_word  (frame_word)
	);

	// conversion and range check
	srfc_convert u_convert (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (frame_valid),
		.in_ready   (conv_ready),
		.in_word    (frame_word),
		.limits     (limits_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	// result packing
	assign m_tuser = result.kind;
	assign m_tdata = {6'd0, result.reset_detected, result.alert_pending, result.heater_on,
		result.word_value, result.humidity_centi, result.temperature_centi,
		result.in_range, result.crc_ok};

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.temp_min <= TEMP_MIN_RST;
			limits_q.temp_max <= TEMP_MAX_RST;
			limits_q.hum_min  <= HUM_MIN_RST;
			limits_q.hum_max  <= HUM_MAX_RST;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_TEMP_MIN: limits_q.temp_min <= pwdata[14:0];
				REG_TEMP_MAX: limits_q.temp_max <= pwdata[14:0];
				REG_HUM_MIN:  limits_q.hum_min  <= pwdata[13:0];
				REG_HUM_MAX:  limits_q.hum_max  <= pwdata[13:0];
				default:      limits_q          <= limits_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_TEMP_MIN: prdata = {17'd0, limits_q.temp_min};
			REG_TEMP_MAX: prdata = {17'd0, limits_q.temp_max};
			REG_HUM_MIN:  prdata = {18'd0, limits_q.hum_min};
			REG_HUM_MAX:  prdata = {18'd0, limits_q.hum_max};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

>>> tb/tb_sensor_response_frame_checker.sv
`timescale 1ns / 1ps
// Self-checking bench for sensor_response_frame_checker: byte stream in, decoded frames out.
// Depends on srfc_pkg and the rtl; a small scoreboard class predicts every result.
module tb_sensor_response_frame_checker;
	import srfc_pkg::*;

	// frame decoder and result store
	class frame_scoreboard;
		result_t     pending_results[$];
		int          errors;
		int          temp_lo, temp_hi;
		int unsigned hum_lo, hum_hi;
		bit          in_frame;
		logic [2:0]  byte_pos;
		logic [1:0]  cur_kind;
		logic [7:0]  crc_acc;
		logic [15:0] word0, word1;
		bit          word0_good;

		function new();
			errors     = 0;
			temp_lo    = int'($signed(TEMP_MIN_RST));
			temp_hi    = int'($signed(TEMP_MAX_RST));
			hum_lo     = 32'(HUM_MIN_RST);
			hum_hi     = 32'(HUM_MAX_RST);
			in_frame   = 1'b0;
			byte_pos   = '0;
			cur_kind   = KIND_MEAS;
			crc_acc    = CRC_INIT;
			word0      = '0;
			word1      = '0;
			word0_good = 1'b0;
		endfunction

		// crc-8 shifted one data bit at a time, msb first
		static function logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] data);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb  = acc[7] ^ data[i];
				acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return acc;
		endfunction

		function void set_limit(input logic [1:0] idx, input logic [31:0] bits);
			case (idx)
				REG_TEMP_MIN: temp_lo = int'($signed(bits[14:0]));
				REG_TEMP_MAX: temp_hi = int'($signed(bits[14:0]));
				REG_HUM_MIN:  hum_lo  = 32'(bits[13:0]);
				default:      hum_hi  = 32'(bits[13:0]);
			endcase
		endfunction

		// decoded values of the frame just completed
		function void push_result(input bit crc_good);
			result_t     r;
			int          t;
			int unsigned h;
			r          = '0;
			r.kind     = cur_kind;
			r.crc_ok   = crc_good;
			if (cur_kind == KIND_MEAS) begin
				t = -4500 + int'((longint'(17500) * word0) / 65535);
				h = int'((longint'(10000) * word1) / 65535);
				r.in_range = crc_good && t >= temp_lo && t <= temp_hi &&
					h >= hum_lo && h <= hum_hi;
				r.temperature_centi = t[14:0];
				r.humidity_centi    = h[13:0];
			end else if (cur_kind == KIND_SERIAL) begin
				r.word_value = {word0, word1};
			end else begin
				r.word_value     = {16'h0000, word0};
				r.heater_on      = word0[13];
				r.alert_pending  = word0[15];
				r.reset_detected = word0[4];
			end
			pending_results.push_back(r);
		endfunction

		// one accepted input transfer
		function void decode_byte(input logic [1:0] op, input logic start, input logic [7:0] b);
			logic [2:0] pos;
			if (start) begin
				byte_pos = '0;
				if (op == KIND_NONE) begin
					in_frame = 1'b0;
					return;
				end
				in_frame   = 1'b1;
				cur_kind   = op;
				crc_acc    = CRC_INIT;
				word0      = '0;
				word1      = '0;
				word0_good = 1'b0;
			end
			if (!in_frame)
				return;
			pos      = byte_pos;
			byte_pos = pos + 3'd1;
			case (pos)
				POS_HI0: begin
					crc_acc = crc_next(crc_acc, b);
					word0   = {b, 8'h00};
				end
				POS_LO0: begin
					crc_acc    = crc_next(crc_acc, b);
					word0[7:0] = b;
				end
				POS_CRC0: begin
					word0_good = (b == crc_acc);
					crc_acc    = CRC_INIT;
					if (cur_kind == KIND_STATUS) begin
						in_frame = 1'b0;
						byte_pos = '0;
						push_result(word0_good);
					end
				end
				POS_HI1: begin
					crc_acc = crc_next(crc_acc, b);
					word1   = {b, 8'h00};
				end
				POS_LO1: begin
					crc_acc    = crc_next(crc_acc, b);
					word1[7:0] = b;
				end
				default: begin
					in_frame = 1'b0;
					byte_pos = '0;
					push_result(word0_good && (b == crc_acc));
					crc_acc = CRC_INIT;
				end
			endcase
		endfunction

		task report_mismatch(input string what, input logic [71:0] got, input logic [71:0] want);
			$display("%0t: mismatch in %s, got 0x%0h, want 0x%0h", $time, what, got, want);
			errors++;
		endtask

		// one accepted output transfer against the oldest prediction
		task check_result(input logic [1:0] kind, input logic [71:0] data);
			result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", data, '0);
				return;
			end
			want = pending_results.pop_front();
			if (kind !== want.kind)
				report_mismatch("kind", 72'(kind), 72'(want.kind));
			if (data[0] !== want.crc_ok)
				report_mismatch("crc_ok", 72'(data[0]), 72'(want.crc_ok));
			if (data[1] !== want.in_range)
				report_mismatch("in_range", 72'(data[1]), 72'(want.in_range));
			if (data[16:2] !== want.temperature_centi)
				report_mismatch("temperature_centi", 72'(data[16:2]),
					72'(want.temperature_centi));
			if (data[30:17] !== want.humidity_centi)
				report_mismatch("humidity_centi", 72'(data[30:17]), 72'(want.humidity_centi));
			if (data[62:31] !== want.word_value)
				report_mismatch("word_value", 72'(data[62:31]), 72'(want.word_value));
			if (data[63] !== want.heater_on)
				report_mismatch("heater_on", 72'(data[63]), 72'(want.heater_on));
			if (data[64] !== want.alert_pending)
				report_mismatch("alert_pending", 72'(data[64]), 72'(want.alert_pending));
			if (data[65] !== want.reset_detected)
				report_mismatch("reset_detected", 72'(data[65]), 72'(want.reset_detected));
			if (data[71:66] !== 6'd0)
				report_mismatch("padding", 72'(data[71:66]), '0);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic [2:0]  s_tuser;   // [1:0] op, [2] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [0] crc_ok, [1] in_range, [16:2] temperature_centi, [30:17] humidity_centi,
	// [62:31] word_value, [63] heater_on, [64] alert_pending, [65] reset_detected, [71:66] zero
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;   // [1:0] kind
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_scoreboard sb;
	int src_idle_pct;
	int snk_stall_pct = 0;
	bit hold_tog = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	sensor_response_frame_checker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= 300;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// one byte transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [1:0] op, input logic start, input logic [7:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= {start, op};
		do @(posedge clk); while (!s_tready);
		sb.decode_byte(op, start, data);
	endtask

	// a frame of the given kind, cut after nbytes; a bad flag corrupts that word's crc byte
	task automatic send_frame(input logic [1:0] kind, input logic [15:0] w0, input logic [15:0] w1,
			input bit bad0, input bit bad1, input int nbytes);
		logic [7:0] frame_bytes [6];
		int         len;
		frame_bytes[0] = w0[15:8];
		frame_bytes[1] = w0[7:0];
		frame_bytes[2] = frame_scoreboard::crc_next(frame_scoreboard::crc_next(CRC_INIT, w0[15:8]),
			w0[7:0]) ^ (bad0 ? 8'($urandom_range(1, 255)) : 8'h00);
		frame_bytes[3] = w1[15:8];
		frame_bytes[4] = w1[7:0];
		frame_bytes[5] = frame_scoreboard::crc_next(frame_scoreboard::crc_next(CRC_INIT, w1[15:8]),
			w1[7:0]) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'h00);
		len = (kind == KIND_STATUS) ? 3 : 6;
		if (nbytes < len)
			len = nbytes;
		for (int i = 0; i < len; i++)
			send_byte((i == 0) ? kind : 2'($urandom_range(3)), i == 0, frame_bytes[i]);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// limit register write over the apb port
	task automatic write_limit(input logic [1:0] idx, input int value);
		logic [31:0] bits;
		bits = (idx == REG_HUM_MIN || idx == REG_HUM_MAX) ? (value & 32'h3FFF) : (value & 32'h7FFF);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= bits;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_limit(idx, bits);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input int t_lo, input int t_hi, input int h_lo, input int h_hi);
		write_limit(REG_TEMP_MIN, t_lo);
		write_limit(REG_TEMP_MAX, t_hi);
		write_limit(REG_HUM_MIN, h_lo);
		write_limit(REG_HUM_MAX, h_hi);
	endtask

	// stop sending and wait for every predicted result, then let the pipeline empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// field extremes and each special case
	task automatic run_directed();
		send_byte(KIND_MEAS, 1'b0, 8'hFF);                       // stray byte while idle
		send_frame(KIND_MEAS, 16'h0000, 16'h0000, 0, 0, 6);
		send_frame(KIND_MEAS, 16'hFFFF, 16'hFFFF, 0, 0, 6);
		send_frame(KIND_SERIAL, 16'h1234, 16'hABCD, 0, 1, 6);     // second crc bad
		send_frame(KIND_MEAS, 16'h6655, 16'h0000, 0, 0, 1);       // dropped by restart
		send_frame(KIND_STATUS, 16'hA010, 16'h0000, 0, 0, 3);
		send_frame(KIND_STATUS, 16'h5FEF, 16'h0000, 1, 0, 3);     // status crc bad
		send_frame(KIND_SERIAL, 16'h8001, 16'h0000, 0, 0, 2);
		send_byte(KIND_NONE, 1'b1, 8'h00);                        // unused kind closes frame
		send_byte(KIND_STATUS, 1'b0, 8'h5A);                      // ignored, idle again
	endtask

	// mostly well-formed frames with random content, some broken ones and noise
	task automatic random_run(input int n);
		int         sent;
		int         pick;
		int         cut;
		logic [1:0] kind;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			kind = 2'($urandom_range(2));
			if (pick < 80) begin
				send_frame(kind, pick_word(), pick_word(), $urandom_range(9) == 0,
					$urandom_range(9) == 0, 6);
				sent += (kind == KIND_STATUS) ? 3 : 6;
			end else if (pick < 88) begin
				// truncated, the next start byte restarts
				cut = $urandom_range(1, (kind == KIND_STATUS) ? 2 : 5);
				send_frame(kind, pick_word(), pick_word(), 0, 0, cut);
				sent += cut;
			end else if (pick < 93) begin
				send_byte(KIND_NONE, 1'b1, 8'($urandom));
				sent++;
			end else if (pick < 97) begin
				send_byte(2'($urandom_range(3)), 1'b0, 8'($urandom));
				sent++;
			end else begin
				send_byte(2'($urandom_range(3)), 1'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		int src_pct [4];
		int snk_pct [4];
		int a, b;
		src_pct = '{0, 67, 0, 15};
		snk_pct = '{0, 0, 67, 15};
		sb = new();
		src_idle_pct = 0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		// phases over limit settings, source idle patterns and sink stall patterns
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_limits(-4500, 13000, 0, 10000);
				1: set_limits(13000, -4500, 10000, 0);
				2: set_limits(2000, 3500, 3000, 7000);
				3: begin
					a = $urandom_range(17500);
					b = $urandom_range(17500);
					set_limits(-4500 + (a < b ? a : b), -4500 + (a < b ? b : a),
						$urandom_range(5000), $urandom_range(5000, 10000));
				end
				default: set_limits(-4000, 12500, 0, 10000);
			endcase
			src_idle_pct = src_pct[p % 4];
			snk_stall_pct <= snk_pct[p % 4];
			random_run(185);
			drain();
		end

		// long receiver hold-off while the sender keeps offering bytes
		src_idle_pct = 0;
		snk_stall_pct <= 0;
		hold_tog <= ~hold_tog;
		for (int i = 0; i < 50; i++)
			send_frame(2'($urandom_range(2)), pick_word(), pick_word(), 0, 0, 6);
		drain();

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
rtl/srfc_pkg.sv
rtl/srfc_frame.sv
rtl/srfc_convert.sv
rtl/sensor_response_frame_checker.sv
tb/tb_sensor_response_frame_checker.sv
